### rtl/arpc_pkg.sv
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the address resolution cache with aging.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int unsigned ENTRIES       = 128;
  localparam int unsigned IP_W          = 32;
  localparam int unsigned MAC_W         = 48;
  localparam int unsigned AGE_W         = 16;
  localparam int unsigned OP_W          = 2;
  localparam int unsigned IN_DATA_W     = 80;
  localparam int unsigned OUT_DATA_W    = 56;
  localparam logic [AGE_W-1:0] AGE_MAX        = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RESET  = AGE_W'(15);

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // beat travelling down the row of cells
  typedef struct packed {
    logic             vld;
    op_t              op;
    logic [IP_W-1:0]  ip;
    logic [MAC_W-1:0] mac;
    logic             hit;
    logic [MAC_W-1:0] found_mac;
    logic             done;
  } beat_t;

endpackage

### rtl/arpc_cell.sv
// ----------------------------------------------------------------------------
// arpc_cell
// One table slot plus the stage register that passes the beat to the next slot.
// ----------------------------------------------------------------------------
module arpc_cell (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 adv,
  input  logic [arpc_pkg::AGE_W-1:0]           timeout,
  input  arpc_pkg::beat_t                      prev,
  output arpc_pkg::beat_t                      nxt
);
  import arpc_pkg::*;

  logic              valid_r, valid_nxt;
  logic [IP_W-1:0]   ip_r, ip_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [AGE_W-1:0]  age_r, age_nxt;
  beat_t             stage_r, stage_nxt;

  always_comb begin
    valid_nxt = valid_r;
    ip_nxt    = ip_r;
    mac_nxt   = mac_r;
    age_nxt   = age_r;
    stage_nxt = prev;
    if (prev.vld) begin
      case (prev.op)
        OP_LOOKUP: begin
          if (valid_r && (ip_r == prev.ip)) begin
            stage_nxt.hit       = 1'b1;
            stage_nxt.found_mac = mac_r;
          end
        end
        OP_INSERT: begin
          if (!valid_r && !prev.done) begin
            valid_nxt      = 1'b1;
            ip_nxt         = prev.ip;
            mac_nxt        = prev.mac;
            age_nxt        = '0;
            stage_nxt.done = 1'b1;
          end
        end
        OP_TICK: begin
          if (valid_r) begin
            if (age_r != AGE_MAX) begin
              age_nxt = age_r + AGE_W'(1);
            end
            if (age_nxt > timeout) begin
              valid_nxt = 1'b0;
            end
          end
        end
        OP_NONE: begin
          stage_nxt = prev;
        end
        default: begin
          stage_nxt = prev;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      stage_r <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
      stage_r <= stage_nxt;
    end
  end

  // slot contents
  always_ff @(posedge clk) begin
    if (adv) begin
      ip_r  <= ip_nxt;
      mac_r <= mac_nxt;
      age_r <= age_nxt;
    end
  end

  assign nxt = stage_r;

`ifndef SYNTHESIS
  a_insert_fills: assert property (@(posedge clk) disable iff (!rst_n)
    adv && prev.vld && prev.op == OP_INSERT && !prev.done && !valid_r
    |=> valid_r && stage_r.done)
    else $error("free slot did not take an insert");

  a_tick_no_revive: assert property (@(posedge clk) disable iff (!rst_n)
    adv && prev.vld && prev.op == OP_TICK && !valid_r |=> !valid_r)
    else $error("tick made a free slot valid");

  a_lookup_match: assert property (@(posedge clk) disable iff (!rst_n)
    adv && prev.vld && prev.op == OP_LOOKUP && valid_r && ip_r == prev.ip
    |=> stage_r.hit && stage_r.found_mac == $past(mac_r))
    else $error("matching slot missed by lookup");
`endif

endmodule

### rtl/arp_cache_with_aging.sv
// ----------------------------------------------------------------------------
// arp_cache_with_aging
// IPv4 to MAC cache of ENTRIES slots with lookup, insert and per-tick aging.
// ----------------------------------------------------------------------------
// Each beat walks a row of ENTRIES slot cells, one cell per cycle while the row
// advances, through each cell's stage register in order; a new beat may enter every
// cycle and a full row never stalls except when the result port holds back.
// The last cell's stage register is the output register. Lookups report the
// highest matching slot, inserts take the lowest free slot, ticks age all
// valid slots and drop those older than the timeout. Reset clears all slots.
module arp_cache_with_aging (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [arpc_pkg::AGE_W-1:0]           cfg_wr_data,   // timeout_seconds
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [arpc_pkg::IN_DATA_W-1:0]       in_tdata,      // ip_addr, mac_addr
  input  logic [arpc_pkg::OP_W-1:0]            in_tuser,      // op
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [arpc_pkg::OUT_DATA_W-1:0]      out_tdata      // hit, found_mac, table_full
);
  import arpc_pkg::*;

  logic [AGE_W-1:0] timeout_r;
  logic             adv;
  beat_t            link [ENTRIES+1];
  beat_t            last;
  logic             table_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  assign last      = link[ENTRIES];
  assign adv       = !last.vld || out_tready;
  assign in_tready = adv;

  always_comb begin
    link[0].vld       = in_tvalid;
    link[0].op        = op_t'(in_tuser);
    link[0].ip        = in_tdata[IP_W-1:0];
    link[0].mac       = in_tdata[IP_W+MAC_W-1:IP_W];
    link[0].hit       = 1'b0;
    link[0].found_mac = '0;
    link[0].done      = 1'b0;
  end

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    arpc_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .timeout (timeout_r),
      .prev    (link[g]),
      .nxt     (link[g+1])
    );
  end

  assign table_full = (last.op == OP_INSERT) && !last.done;
  assign out_tvalid = last.vld;
  assign out_tdata  = {(OUT_DATA_W-MAC_W-2)'(0), table_full, last.found_mac, last.hit};

`ifndef SYNTHESIS
  a_hit_only_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    last.vld && last.hit |-> last.op == OP_LOOKUP)
    else $error("hit on a beat that is not a lookup");

  a_mac_zero_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    last.vld && !last.hit |-> last.found_mac == '0)
    else $error("mac reported without a hit");

  a_full_only_insert: assert property (@(posedge clk) disable iff (!rst_n)
    last.vld && last.done |-> last.op == OP_INSERT)
    else $error("slot claimed by a beat that is not an insert");
`endif

endmodule
